// ===== sv/tpsi_pkg.sv =====
// Shared types and constants for the terrain patch LOD stitch indexer.
// No dependencies; used by tpsi_cell_front, tpsi_fan_seq and the top level.
package tpsi_pkg;

   localparam int IDX_W        = 11;
   localparam int NUM_SIDES    = 4;
   localparam int NUM_LOD_REGS = 3;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 40;
   localparam int RSP_PAD_W    = RSP_DATA_W - 3 * IDX_W;

   localparam logic [2:0] LOG2_MIN = 3'd2;
   localparam logic [2:0] LOG2_MAX = 3'd5;

   // register indexes of the configuration port
   localparam logic [1:0] REG_GRIDS_LOG2_LOD0 = 2'd0;
   localparam logic [1:0] REG_GRIDS_LOG2_LOD1 = 2'd1;
   localparam logic [1:0] REG_GRIDS_LOG2_LOD2 = 2'd2;

   typedef logic [NUM_LOD_REGS-1:0][2:0] lod_cfg_type;

   localparam lod_cfg_type GRIDS_LOG2_RESET = {3'd2, 3'd3, 3'd4};

   // side order is also the emission order; corner[s] is the first corner of side s
   typedef enum logic [1:0] {
      SIDE_TOP    = 2'd0,
      SIDE_RIGHT  = 2'd1,
      SIDE_BOTTOM = 2'd2,
      SIDE_LEFT   = 2'd3
   } side_type;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [4:0]                  cell_col;
      logic [4:0]                  cell_row;
      logic [NUM_SIDES-1:0][1:0]   side_lod;
      logic [1:0]                  patch_lod;
   } cell_req_type;

   typedef struct packed {
      logic                        err;
      idx_type                     centre;
      idx_type [NUM_SIDES-1:0]     corner;
      logic [NUM_SIDES-1:0]        fan;
      logic [NUM_SIDES-1:0][1:0]   shift;
      idx_type [NUM_SIDES-1:0]     delta;
      idx_type [NUM_SIDES-1:0]     start;
   } tri_job_type;

   // bottom and left fans walk their edge vertices backwards
   function automatic logic is_reverse(input side_type sd);
      return (sd == SIDE_BOTTOM) || (sd == SIDE_LEFT);
   endfunction

   // number of intermediate edge vertices on a side
   function automatic logic [2:0] fan_count(input logic fan, input logic [1:0] sh);
      logic [3:0] sub;
      sub = 4'd1 << sh;
      return fan ? 3'(sub - 4'd1) : 3'd0;
   endfunction

endpackage

// ===== sv/tpsi_cell_front.sv =====
// Five-stage elastic pipeline: level checks, cell geometry, vertex indices
// and fan start points for one cell. Depends on tpsi_pkg.
module tpsi_cell_front #(
   parameter int SIDE_VERTS = 33,
   parameter int LOD_COUNT  = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tpsi_pkg::cell_req_type in_req,
   input  tpsi_pkg::lod_cfg_type  cfg,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tpsi_pkg::tri_job_type  out_job
);
   import tpsi_pkg::*;

   localparam int CW = $clog2(SIDE_VERTS);
   localparam logic [CW-1:0] LAST_POS = CW'(SIDE_VERTS - 1);
   localparam logic [2:0] LOD_LIM = 3'(LOD_COUNT);

   function automatic logic [3:0] lod_log2(input logic [1:0] lod, input lod_cfg_type c);
      logic [2:0] lg;
      logic       bad;
      if ({1'b0, lod} >= LOD_LIM) begin
         bad = 1'b1;
         lg  = LOG2_MIN;
      end else begin
         case (lod)
            2'd0:    lg = c[0];
            2'd1:    lg = c[1];
            default: lg = c[2];
         endcase
         bad = (lg < LOG2_MIN) || (lg > LOG2_MAX);
      end
      return {bad, lg};
   endfunction

   function automatic idx_type vidx(input logic [CW-1:0] yy, input logic [CW-1:0] xx);
      logic [CW+8:0] t;
      t = (CW+9)'(yy) * (CW+9)'(SIDE_VERTS) + (CW+9)'(xx);
      return t[IDX_W-1:0];
   endfunction

   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // ---------------- stage 1: levels, range checks, border fans
   logic                      s1_valid_ff;
   logic                      s1_err_ff, s1_err_in;
   logic [2:0]                s1_p_ff, s1_p_in;
   logic [4:0]                s1_row_ff, s1_col_ff;
   logic                      s1_right_ff, s1_bottom_ff;
   logic [NUM_SIDES-1:0]      s1_border_in;
   logic [NUM_SIDES-1:0]      s1_fan_ff, s1_fan_in;
   logic [NUM_SIDES-1:0][1:0] s1_sh_ff, s1_sh_in;

   always_comb begin
      logic [NUM_SIDES-1:0][2:0] lg;
      logic       nb_bad;
      logic       p_bad;
      logic [5:0] g;
      logic [5:0] gm1;
      {p_bad, s1_p_in} = lod_log2(in_req.patch_lod, cfg);
      s1_err_in = p_bad;
      for (int sd = 0; sd < NUM_SIDES; sd++) begin
         {nb_bad, lg[sd]} = lod_log2(in_req.side_lod[sd], cfg);
         s1_err_in = s1_err_in | nb_bad;
      end
      g   = 6'd1 << s1_p_in;
      gm1 = g - 6'd1;
      if (({1'b0, in_req.cell_row} >= g) || ({1'b0, in_req.cell_col} >= g)) begin
         s1_err_in = 1'b1;
      end
      s1_border_in[SIDE_TOP]    = (in_req.cell_row == 5'd0);
      s1_border_in[SIDE_RIGHT]  = ({1'b0, in_req.cell_col} == gm1);
      s1_border_in[SIDE_BOTTOM] = ({1'b0, in_req.cell_row} == gm1);
      s1_border_in[SIDE_LEFT]   = (in_req.cell_col == 5'd0);
      for (int sd = 0; sd < NUM_SIDES; sd++) begin
         s1_fan_in[sd] = s1_border_in[sd] && (lg[sd] > s1_p_in);
         s1_sh_in[sd]  = 2'(lg[sd] - s1_p_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rdy1) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_err_ff    <= s1_err_in;
         s1_p_ff      <= s1_p_in;
         s1_row_ff    <= in_req.cell_row;
         s1_col_ff    <= in_req.cell_col;
         s1_right_ff  <= s1_border_in[SIDE_RIGHT];
         s1_bottom_ff <= s1_border_in[SIDE_BOTTOM];
         s1_fan_ff    <= s1_fan_in;
         s1_sh_ff     <= s1_sh_in;
      end
   end

   // ---------------- stage 2: grid size, cell origin, fan step
   logic                        s2_valid_ff;
   logic                        s2_err_ff;
   logic [CW-1:0]               s2_s_ff, s2_s_in;
   logic [CW-1:0]               s2_x_ff, s2_x_in, s2_y_ff, s2_y_in;
   logic                        s2_right_ff, s2_bottom_ff;
   logic [NUM_SIDES-1:0]        s2_fan_ff;
   logic [NUM_SIDES-1:0][1:0]   s2_sh_ff;
   logic [NUM_SIDES-1:0][CW-1:0] s2_step_ff, s2_step_in;

   always_comb begin
      logic [CW+4:0] xp;
      logic [CW+4:0] yp;
      s2_s_in = LAST_POS >> s1_p_ff;
      xp = (CW+5)'(s1_col_ff) * (CW+5)'(s2_s_in);
      yp = (CW+5)'(s1_row_ff) * (CW+5)'(s2_s_in);
      s2_x_in = xp[CW-1:0];
      s2_y_in = yp[CW-1:0];
      for (int sd = 0; sd < NUM_SIDES; sd++) begin
         s2_step_in[sd] = s2_s_in >> s1_sh_ff[sd];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (rdy2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_err_ff    <= s1_err_ff;
         s2_s_ff      <= s2_s_in;
         s2_x_ff      <= s2_x_in;
         s2_y_ff      <= s2_y_in;
         s2_right_ff  <= s1_right_ff;
         s2_bottom_ff <= s1_bottom_ff;
         s2_fan_ff    <= s1_fan_ff;
         s2_sh_ff     <= s1_sh_ff;
         s2_step_ff   <= s2_step_in;
      end
   end

   // ---------------- stage 3: far corner and centre coordinates
   logic                         s3_valid_ff;
   logic                         s3_err_ff;
   logic [CW-1:0]                s3_x_ff, s3_y_ff;
   logic [CW-1:0]                s3_x1_ff, s3_x1_in, s3_y1_ff, s3_y1_in;
   logic [CW-1:0]                s3_cx_ff, s3_cx_in, s3_cy_ff, s3_cy_in;
   logic [NUM_SIDES-1:0]         s3_fan_ff;
   logic [NUM_SIDES-1:0][1:0]    s3_sh_ff;
   logic [NUM_SIDES-1:0][CW-1:0] s3_step_ff;

   always_comb begin
      // last column/row snaps to the patch edge
      s3_x1_in = s2_right_ff  ? LAST_POS : s2_x_ff + s2_s_ff;
      s3_y1_in = s2_bottom_ff ? LAST_POS : s2_y_ff + s2_s_ff;
      s3_cx_in = s2_x_ff + (s2_s_ff >> 1);
      s3_cy_in = s2_y_ff + (s2_s_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (rdy3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_err_ff  <= s2_err_ff;
         s3_x_ff    <= s2_x_ff;
         s3_y_ff    <= s2_y_ff;
         s3_x1_ff   <= s3_x1_in;
         s3_y1_ff   <= s3_y1_in;
         s3_cx_ff   <= s3_cx_in;
         s3_cy_ff   <= s3_cy_in;
         s3_fan_ff  <= s2_fan_ff;
         s3_sh_ff   <= s2_sh_ff;
         s3_step_ff <= s2_step_ff;
      end
   end

   // ---------------- stage 4: vertex indices of centre, corners and fan steps
   logic                      s4_valid_ff;
   logic                      s4_err_ff;
   idx_type                   s4_centre_ff, s4_centre_in;
   idx_type [NUM_SIDES-1:0]   s4_corner_ff, s4_corner_in;
   idx_type [NUM_SIDES-1:0]   s4_delta_ff, s4_delta_in;
   logic [NUM_SIDES-1:0]      s4_fan_ff;
   logic [NUM_SIDES-1:0][1:0] s4_sh_ff;

   always_comb begin
      s4_centre_in              = vidx(s3_cy_ff, s3_cx_ff);
      s4_corner_in[SIDE_TOP]    = vidx(s3_y_ff,  s3_x_ff);
      s4_corner_in[SIDE_RIGHT]  = vidx(s3_y_ff,  s3_x1_ff);
      s4_corner_in[SIDE_BOTTOM] = vidx(s3_y1_ff, s3_x1_ff);
      s4_corner_in[SIDE_LEFT]   = vidx(s3_y1_ff, s3_x_ff);
      s4_delta_in[SIDE_TOP]     = IDX_W'(s3_step_ff[SIDE_TOP]);
      s4_delta_in[SIDE_BOTTOM]  = IDX_W'(s3_step_ff[SIDE_BOTTOM]);
      s4_delta_in[SIDE_RIGHT]   = vidx(s3_step_ff[SIDE_RIGHT], '0);
      s4_delta_in[SIDE_LEFT]    = vidx(s3_step_ff[SIDE_LEFT], '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (rdy4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_err_ff    <= s3_err_ff;
         s4_centre_ff <= s4_centre_in;
         s4_corner_ff <= s4_corner_in;
         s4_delta_ff  <= s4_delta_in;
         s4_fan_ff    <= s3_fan_ff;
         s4_sh_ff     <= s3_sh_ff;
      end
   end

   // ---------------- stage 5: first intermediate vertex of each fan
   logic        s5_valid_ff;
   tri_job_type s5_job_ff, s5_job_in;

   always_comb begin
      side_type sd_t;
      side_type nx_t;
      s5_job_in.err    = s4_err_ff;
      s5_job_in.centre = s4_centre_ff;
      s5_job_in.corner = s4_corner_ff;
      s5_job_in.fan    = s4_fan_ff;
      s5_job_in.shift  = s4_sh_ff;
      s5_job_in.delta  = s4_delta_ff;
      for (int sd = 0; sd < NUM_SIDES; sd++) begin
         sd_t = side_type'(2'(sd));
         nx_t = side_type'(2'(sd + 1));
         // reversed fans start next to the side's first corner, offset from the far corner
         if (is_reverse(sd_t)) begin
            s5_job_in.start[sd] = s4_corner_ff[nx_t]
                                + (s4_delta_ff[sd] << s4_sh_ff[sd]) - s4_delta_ff[sd];
         end else begin
            s5_job_in.start[sd] = s4_corner_ff[sd] + s4_delta_ff[sd];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (rdy5) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         s5_job_ff <= s5_job_in;
      end
   end

   assign rdy5      = !s5_valid_ff || out_ready;
   assign rdy4      = !s4_valid_ff || rdy5;
   assign rdy3      = !s3_valid_ff || rdy4;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign in_ready  = rdy1;
   assign out_valid = s5_valid_ff;
   assign out_job   = s5_job_ff;

endmodule

// ===== sv/tpsi_fan_seq.sv =====
// Triangle sequencer: walks the four sides of one cell job, one triangle a
// cycle unless stalled, into a registered output. Depends on tpsi_pkg.
module tpsi_fan_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_valid,
   output logic                                job_ready,
   input  tpsi_pkg::tri_job_type               job,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tpsi_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser
);
   import tpsi_pkg::*;

   logic        busy_ff, busy_in;
   side_type    side_ff, side_in;
   logic [2:0]  cnt_ff, cnt_in;
   idx_type     prev_ff, prev_in;
   idx_type     run_ff, run_in;
   tri_job_type job_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_err_ff;

   logic       out_free, emit, finish, take;
   logic [1:0] nxt_code;
   side_type   nxt_side;
   idx_type    far_corner;
   idx_type    tri_a, tri_b, tri_c;

   always_comb begin
      nxt_code   = side_ff + 2'd1;
      nxt_side   = side_type'(nxt_code);
      far_corner = job_ff.corner[nxt_side];
      out_free   = !rsp_valid_ff || rsp_tready;
      emit       = busy_ff && out_free;
      finish     = job_ff.err || ((side_ff == SIDE_LEFT) && (cnt_ff == 3'd0));
      job_ready  = !busy_ff || (emit && finish);
      take       = job_valid && job_ready;

      busy_in = busy_ff;
      side_in = side_ff;
      cnt_in  = cnt_ff;
      prev_in = prev_ff;
      run_in  = run_ff;
      if (take) begin
         busy_in = 1'b1;
         side_in = SIDE_TOP;
         prev_in = job.corner[SIDE_TOP];
         run_in  = job.start[SIDE_TOP];
         cnt_in  = fan_count(job.fan[SIDE_TOP], job.shift[SIDE_TOP]);
      end else if (emit && finish) begin
         busy_in = 1'b0;
      end else if (emit) begin
         if (cnt_ff != 3'd0) begin
            prev_in = run_ff;
            run_in  = is_reverse(side_ff) ? run_ff - job_ff.delta[side_ff]
                                          : run_ff + job_ff.delta[side_ff];
            cnt_in  = cnt_ff - 3'd1;
         end else begin
            side_in = nxt_side;
            prev_in = far_corner;
            run_in  = job_ff.start[nxt_side];
            cnt_in  = fan_count(job_ff.fan[nxt_side], job_ff.shift[nxt_side]);
         end
      end

      if (job_ff.err) begin
         tri_a = '0;
         tri_b = '0;
         tri_c = '0;
      end else begin
         tri_a = job_ff.centre;
         tri_b = prev_ff;
         tri_c = (cnt_ff != 3'd0) ? run_ff : far_corner;
      end
      rsp_data_in  = {{RSP_PAD_W{1'b0}}, tri_c, tri_b, tri_a};
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         side_ff      <= SIDE_TOP;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         side_ff      <= side_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      run_ff  <= run_in;
      if (take) begin
         job_ff <= job;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= finish;
         rsp_err_ff  <= job_ff.err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   // intermediate vertices only exist on fan sides
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && !job_ff.err && (cnt_ff != 3'd0) |-> job_ff.fan[side_ff])
      else $error("fan counter running on a plain side");

   // an error transaction is a single zeroed triangle closing its cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("malformed error transaction");

   // the sequencer goes idle after the last triangle when nothing is queued
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && emit && finish && !job_valid |=> !busy_ff)
      else $error("sequencer stayed busy after last triangle");

endmodule

// ===== sv/terrain_patch_lod_stitch_indexer.sv =====
// Top level of the terrain patch LOD stitch indexer: stream ports, config
// registers. Depends on tpsi_pkg, tpsi_cell_front and tpsi_fan_seq.
//
// Takes one grid cell per request transaction and returns its triangles as
// vertex index triples, top, right, bottom, left, one response transaction
// per triangle; tlast marks the cell's final triangle. A cell has 4
// triangles with no finer neighbour, up to 18 for a corner cell with two
// fanned borders; out-of-range cells or levels return one error triangle
// (tuser set). The triangle sequencer emits one triangle a cycle unless the
// response stalls; a 5-stage geometry pipeline in front of it accepts a new
// cell every cycle while there is room. Config writes are taken at any time,
// but must only be issued while the block is idle.
module terrain_patch_lod_stitch_indexer #(
   parameter int SIDE_VERTS = 33,
   parameter int LOD_COUNT  = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   // fields from bit 0: patch_lod[1:0], left_lod[3:2], top_lod[5:4],
   // right_lod[7:6], bottom_lod[9:8], cell_row[14:10], cell_col[19:15]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tpsi_pkg::REQ_DATA_W-1:0]   req_tdata,
   // fields from bit 0: vertex_a[10:0], vertex_b[21:11], vertex_c[32:22]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tpsi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,   // last_triangle
   output logic                              rsp_tuser,   // request_error
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [2:0]                        csr_wdata
);
   import tpsi_pkg::*;

   lod_cfg_type  grids_log2_ff, grids_log2_in;
   cell_req_type cell_req;
   logic         job_valid, job_ready;
   tri_job_type  job;

   assign csr_ready = 1'b1;

   always_comb begin
      grids_log2_in = grids_log2_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_GRIDS_LOG2_LOD0: grids_log2_in[0] = csr_wdata;
            REG_GRIDS_LOG2_LOD1: grids_log2_in[1] = csr_wdata;
            REG_GRIDS_LOG2_LOD2: grids_log2_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grids_log2_ff <= GRIDS_LOG2_RESET;
      end else begin
         grids_log2_ff <= grids_log2_in;
      end
   end

   always_comb begin
      cell_req.patch_lod             = req_tdata[1:0];
      cell_req.side_lod[SIDE_LEFT]   = req_tdata[3:2];
      cell_req.side_lod[SIDE_TOP]    = req_tdata[5:4];
      cell_req.side_lod[SIDE_RIGHT]  = req_tdata[7:6];
      cell_req.side_lod[SIDE_BOTTOM] = req_tdata[9:8];
      cell_req.cell_row              = req_tdata[14:10];
      cell_req.cell_col              = req_tdata[19:15];
   end

   tpsi_cell_front #(
      .SIDE_VERTS (SIDE_VERTS),
      .LOD_COUNT  (LOD_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_req    (cell_req),
      .cfg       (grids_log2_ff),
      .out_valid (job_valid),
      .out_ready (job_ready),
      .out_job   (job)
   );

   tpsi_fan_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== test/terrain_patch_lod_stitch_indexer_test.sv =====
// Self-checking testbench for terrain_patch_lod_stitch_indexer: drives grid cells,
// predicts each cell's triangle stream and compares it transaction by transaction.
// Depends on tpsi_pkg and the terrain_patch_lod_stitch_indexer top level.
`timescale 1ns / 1ps

module terrain_patch_lod_stitch_indexer_test;
   import tpsi_pkg::*;

   localparam int GRID_VERTS     = 33;
   localparam int LOD_LEVELS     = 3;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;

   typedef struct packed {
      logic [1:0] patch_lod;
      logic [1:0] left_lod;
      logic [1:0] top_lod;
      logic [1:0] right_lod;
      logic [1:0] bottom_lod;
      logic [4:0] cell_row;
      logic [4:0] cell_col;
   } cell_item_type;

   typedef struct packed {
      idx_type vertex_a;
      idx_type vertex_b;
      idx_type vertex_c;
      logic    last_triangle;
      logic    request_error;
   } triangle_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [1:0]            csr_index;
   logic [2:0]            csr_wdata;

   lod_cfg_type  grid_log2 = GRIDS_LOG2_RESET;
   triangle_type pending_tris[$];
   int unsigned  mismatch_count = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  hold_request = 0;
   bit           idle_on = 1;

   terrain_patch_lod_stitch_indexer #(
      .SIDE_VERTS (GRID_VERTS),
      .LOD_COUNT  (LOD_LEVELS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic int unsigned vertex_at(input int unsigned vx, input int unsigned vy);
      return vy * GRID_VERTS + vx;
   endfunction

   function automatic void push_triangle(input int unsigned a, input int unsigned b,
                                         input int unsigned c, input bit last, input bit err);
      triangle_type t;
      t.vertex_a      = idx_type'(a);
      t.vertex_b      = idx_type'(b);
      t.vertex_c      = idx_type'(c);
      t.last_triangle = last;
      t.request_error = err;
      pending_tris = {pending_tris, t};
   endfunction

   function automatic void predict_triangles(input cell_item_type cl);
      logic [1:0]  lv [5];
      int unsigned lg [5];
      int unsigned corner [4];
      bit          bad, border, rev;
      int unsigned p, g, s, x, y, x1, y1, ctr, nb, sh, sub, step;
      int unsigned bx, by, sx, sy, prev, v, i;
      side_type    sd;
      lv = '{cl.patch_lod, cl.left_lod, cl.top_lod, cl.right_lod, cl.bottom_lod};
      bad = 0;
      for (int k = 0; k < 5; k++) begin
         if (lv[k] >= LOD_LEVELS) begin
            bad = 1;
            lg[k] = LOG2_MIN;
         end else begin
            lg[k] = grid_log2[lv[k]];
            if (lg[k] < LOG2_MIN || lg[k] > LOG2_MAX) bad = 1;
         end
      end
      p = lg[0];
      g = 1 << p;
      if (!bad && (cl.cell_row >= g || cl.cell_col >= g)) bad = 1;
      if (bad) begin
         push_triangle(0, 0, 0, 1, 1);
         return;
      end
      s  = (GRID_VERTS - 1) >> p;
      x  = cl.cell_col * s;
      y  = cl.cell_row * s;
      x1 = (cl.cell_col == g - 1) ? GRID_VERTS - 1 : x + s;
      y1 = (cl.cell_row == g - 1) ? GRID_VERTS - 1 : y + s;
      ctr = vertex_at(x + s / 2, y + s / 2);
      corner[0] = vertex_at(x, y);
      corner[1] = vertex_at(x1, y);
      corner[2] = vertex_at(x1, y1);
      corner[3] = vertex_at(x, y1);
      // side k runs from corner[k] to corner[k+1]; bottom and left walk backwards
      for (int k = 0; k < NUM_SIDES; k++) begin
         sd = side_type'(k);
         case (sd)
            SIDE_TOP: begin
               border = (cl.cell_row == 0); nb = lg[2];
               bx = x; by = y; sx = 1; sy = 0; rev = 0;
            end
            SIDE_RIGHT: begin
               border = (cl.cell_col == g - 1); nb = lg[3];
               bx = x1; by = y; sx = 0; sy = 1; rev = 0;
            end
            SIDE_BOTTOM: begin
               border = (cl.cell_row == g - 1); nb = lg[4];
               bx = x; by = y1; sx = 1; sy = 0; rev = 1;
            end
            default: begin
               border = (cl.cell_col == 0); nb = lg[1];
               bx = x; by = y; sx = 0; sy = 1; rev = 1;
            end
         endcase
         sh   = (border && p < nb) ? nb - p : 0;
         sub  = 1 << sh;
         step = s >> sh;
         prev = corner[k];
         for (int j = 1; j < sub; j++) begin
            i = rev ? sub - j : j;
            v = vertex_at(bx + sx * step * i, by + sy * step * i);
            push_triangle(ctr, prev, v, 0, 0);
            prev = v;
         end
         push_triangle(ctr, prev, corner[(k + 1) % NUM_SIDES], k == NUM_SIDES - 1, 0);
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : triangle_checker
      triangle_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tris.size() == 0) begin
            $error("unexpected triangle transaction: tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_tris.pop_front();
            check_field("vertex_a", want.vertex_a, rsp_tdata[10:0]);
            check_field("vertex_b", want.vertex_b, rsp_tdata[21:11]);
            check_field("vertex_c", want.vertex_c, rsp_tdata[32:22]);
            check_field("last_triangle", want.last_triangle, rsp_tlast);
            check_field("request_error", want.request_error, rsp_tuser);
         end
      end
   end

   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- idling

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 15) return $urandom_range(1, 2);
      if (r < 19) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   initial begin : rsp_ready_driver
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (!idle_on) begin
            rsp_tready = 1'b1;
         end else begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            if (stall_left != 0) begin
               rsp_tready = 1'b0;
               stall_left--;
            end else begin
               rsp_tready = 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic cell_item_type make_cell(input logic [1:0] pl, input logic [1:0] ll,
                                               input logic [1:0] tl, input logic [1:0] rl,
                                               input logic [1:0] bl, input logic [4:0] row,
                                               input logic [4:0] col);
      cell_item_type cl;
      cl.patch_lod  = pl;
      cl.left_lod   = ll;
      cl.top_lod    = tl;
      cl.right_lod  = rl;
      cl.bottom_lod = bl;
      cl.cell_row   = row;
      cl.cell_col   = col;
      return cl;
   endfunction

   // border rows and columns are where the fans live, so favor them
   function automatic logic [4:0] pick_coord(input int unsigned g);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 3) return 5'd0;
      if (r < 6) return 5'(g - 1);
      return 5'($urandom_range(0, g - 1));
   endfunction

   function automatic cell_item_type random_cell();
      cell_item_type cl;
      int unsigned   g;
      if ($urandom_range(0, 9) == 0) begin
         return make_cell(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          2'($urandom_range(0, 3)),
                          5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      end
      cl = make_cell(2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)),
                     2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)),
                     2'($urandom_range(0, 2)), 0, 0);
      g = 1 << grid_log2[cl.patch_lod];
      if (g > 32) g = 32;
      cl.cell_row = pick_coord(g);
      cl.cell_col = pick_coord(g);
      return cl;
   endfunction

   task automatic send_cell(input cell_item_type cl, input bit back_to_back);
      int unsigned gap;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, cl.cell_col, cl.cell_row, cl.bottom_lod, cl.right_lod,
                    cl.top_lod, cl.left_lod, cl.patch_lod};
      do @(posedge clock); while (!req_tready);
      predict_triangles(cl);
      gap = (back_to_back || !idle_on || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic run_random_cells(input int unsigned count);
      repeat (count) send_cell(random_cell(), 0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_tris.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_grid_log2(input logic [1:0] index, input logic [2:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      grid_log2[index] = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_config(input logic [2:0] lod0, input logic [2:0] lod1,
                               input logic [2:0] lod2);
      wait_drained();
      write_grid_log2(REG_GRIDS_LOG2_LOD0, lod0);
      write_grid_log2(REG_GRIDS_LOG2_LOD1, lod1);
      write_grid_log2(REG_GRIDS_LOG2_LOD2, lod2);
   endtask

   // ---------------------------------------------------------------- tests

   // reset register values: 16, 8 and 4 cells per side
   task automatic test_reset_defaults();
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 0), 0);
      send_cell(make_cell(0, 0, 0, 0, 0, 7, 9), 0);
      send_cell(make_cell(2, 0, 0, 0, 0, 0, 0), 0);     // top and left fans
      send_cell(make_cell(2, 0, 0, 0, 0, 3, 3), 0);     // right and bottom fans
      send_cell(make_cell(1, 0, 0, 0, 0, 0, 5), 0);
      send_cell(make_cell(1, 2, 2, 2, 2, 0, 0), 0);     // coarser neighbors, no fan
      send_cell(make_cell(0, 0, 0, 0, 0, 15, 15), 0);
      send_cell(make_cell(3, 0, 0, 0, 0, 0, 0), 0);     // bad patch level
      send_cell(make_cell(0, 3, 0, 0, 0, 0, 0), 0);
      send_cell(make_cell(0, 0, 3, 0, 0, 0, 0), 0);
      send_cell(make_cell(0, 0, 0, 3, 0, 0, 0), 0);
      send_cell(make_cell(0, 0, 0, 0, 3, 0, 0), 0);
      send_cell(make_cell(2, 0, 0, 0, 0, 4, 0), 0);     // row past the grid
      send_cell(make_cell(2, 0, 0, 0, 0, 0, 31), 0);    // column past the grid
      send_cell(make_cell(3, 3, 3, 3, 3, 31, 31), 0);
      send_cell(make_cell(0, 0, 0, 0, 0, 31, 0), 0);
   endtask

   // coarsest patch against finest neighbor gives the widest fans
   task automatic test_fan_extremes();
      apply_config(2, 5, 3);
      send_cell(make_cell(0, 1, 1, 1, 1, 0, 0), 0);
      send_cell(make_cell(0, 1, 1, 1, 1, 3, 3), 0);
      send_cell(make_cell(0, 2, 2, 2, 2, 0, 3), 0);
      send_cell(make_cell(1, 0, 0, 0, 0, 31, 31), 0);
      send_cell(make_cell(1, 1, 1, 1, 1, 0, 17), 0);
   endtask

   // register values outside the legal range turn any cell that uses them into an error
   task automatic test_register_range();
      apply_config(7, 6, 2);
      run_random_cells(15);
      apply_config(0, 1, 5);
      run_random_cells(15);
   endtask

   task automatic test_random_configs();
      apply_config(5, 5, 5);
      run_random_cells(20);
      apply_config(3, 4, 5);
      idle_on = 0;                                     // a stretch at full rate
      run_random_cells(20);
      idle_on = 1;
      apply_config(5, 3, 2);
      run_random_cells(20);
      apply_config(2, 3, 4);
      run_random_cells(20);
   endtask

   // receiver holds off while cells keep coming, so the input must stall
   task automatic test_backpressure();
      wait_drained();
      @(posedge clock);
      hold_request = HOLD_CYCLES;
      repeat (40) send_cell(random_cell(), 1);
      wait_drained();
   endtask

   // sender goes quiet until every triangle has come back, then resumes
   task automatic test_drain_pause();
      run_random_cells(10);
      wait_drained();
      run_random_cells(10);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = REG_GRIDS_LOG2_LOD0;
      csr_wdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_fan_extremes();
      test_register_range();
      test_random_configs();
      test_backpressure();
      test_drain_pause();
      wait_drained();

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tpsi_pkg.sv
sv/tpsi_cell_front.sv
sv/tpsi_fan_seq.sv
sv/terrain_patch_lod_stitch_indexer.sv
test/terrain_patch_lod_stitch_indexer_test.sv
